// ===== src/hblt_pkg.sv =====
// Shared types and codes for the heartbeat liveness table.
`timescale 1ns / 1ps
package hblt_pkg;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_PONG   = 2'd2,
      MODE_TICK   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_PING   = 2'd1,
      KIND_DEAD   = 2'd2
   } kind_type;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam int LOSS_SCALE = 100;

   typedef struct packed {
      logic [1:0]  mode;
      logic [47:0] client_addr;
      logic [9:0]  ping_span;
      logic [6:0]  allowed_loss;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] out_addr;
      logic [9:0]  ping_value;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } eng_state_type;

endpackage

// ===== src/heartbeat_liveness_table.sv =====
// Top level of the heartbeat liveness table.
// Usage:
//   Requests enter on req_word when req_push is high and req_full is low.
//   Modes add, remove and pong give one status word each; a tick gives one
//   word per stored peer (ping or dead report), none on an empty table.
//   The final word caused by a request carries last = 1.
//   Results wait on rsp_word while rsp_empty is low and leave on rsp_pop.
// Timing:
//   A request lands in a two-entry queue when accepted and is taken by the
//   engine once it is idle and the result register is free.
//   Add, remove and pong are answered straight from the idle state: the
//   status word is registered onto rsp_word, and one word per cycle can
//   follow while the receiver keeps popping. A tick on a non-empty table
//   starts a walk that writes one word per stored peer in table order and
//   is held by a stalled receiver; no request is taken until the walk ends.
//   A tick on an empty table is retired with no words.
// Reset clears the peer count and walk state and empties the queue and the result register.
// A stalled receiver holds the engine; the queue then fills and raises
// req_full.
`timescale 1ns / 1ps
module heartbeat_liveness_table #(
   parameter int MAX_PEERS = 16,
   parameter int SPAN_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  hblt_pkg::req_type  req_word,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output hblt_pkg::rsp_type  rsp_word
);

   logic              cmd_valid;
   logic              cmd_take;
   hblt_pkg::req_type cmd_word;

   hblt_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .push_word (req_word),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_word  (cmd_word)
   );

   hblt_engine #(
      .MAX_PEERS (MAX_PEERS),
      .SPAN_BITS (SPAN_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_word  (cmd_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== src/hblt_cmd_queue.sv =====
// Two-entry request queue between the input port and the table engine.
`timescale 1ns / 1ps
module hblt_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  hblt_pkg::req_type push_word,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output hblt_pkg::req_type cmd_word
);

   hblt_pkg::req_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_word  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== src/hblt_engine.sv =====
// Peer table and sequencer: add/remove/pong in one step, tick walks the table.
`timescale 1ns / 1ps
module hblt_engine #(
   parameter int MAX_PEERS = 16,
   parameter int SPAN_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  hblt_pkg::req_type  cmd_word,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output hblt_pkg::rsp_type  rsp_word
);

   localparam int IDX_W  = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int CNT_W  = $clog2(MAX_PEERS + 1);
   localparam int PROD_W = SPAN_BITS + 9;
   localparam logic [SPAN_BITS-1:0] SPAN_MAX = {SPAN_BITS{1'b1}};

   logic [47:0]          addr_ff    [MAX_PEERS];
   logic [47:0]          addr_in    [MAX_PEERS];
   logic [SPAN_BITS-1:0] span_ff    [MAX_PEERS];
   logic [SPAN_BITS-1:0] span_in    [MAX_PEERS];
   logic [6:0]           allowed_ff [MAX_PEERS];
   logic [6:0]           allowed_in [MAX_PEERS];
   logic [SPAN_BITS-1:0] ping_ff    [MAX_PEERS];
   logic [SPAN_BITS-1:0] ping_in    [MAX_PEERS];
   logic [SPAN_BITS-1:0] pong_ff    [MAX_PEERS];
   logic [SPAN_BITS-1:0] pong_in    [MAX_PEERS];

   logic [CNT_W-1:0]        total_ff, total_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   hblt_pkg::eng_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   hblt_pkg::rsp_type       rsp_ff, rsp_in;

   logic                    out_free;
   logic [MAX_PEERS-1:0]    hit;
   logic                    found;
   logic [IDX_W-1:0]        hit_idx;
   logic                    drop_en;
   logic [IDX_W-1:0]        drop_idx;

   logic [SPAN_BITS-1:0]    cur_span, cur_ping, cur_pong;
   logic [6:0]              cur_allowed;
   logic signed [SPAN_BITS:0]  missed;
   logic signed [PROD_W-1:0]   loss_lhs, loss_rhs;
   logic                    lost;
   logic                    walk_last;

   // parallel key match over the occupied slots
   always_comb begin
      hit_idx = '0;
      for (int j = 0; j < MAX_PEERS; j++) begin
         hit[j] = (j < int'(total_ff)) && (addr_ff[j] == cmd_word.client_addr);
      end
      for (int j = MAX_PEERS - 1; j >= 0; j--) begin
         if (hit[j]) hit_idx = IDX_W'(j);
      end
      found = |hit;
   end

   assign cur_span    = span_ff[idx_ff];
   assign cur_ping    = ping_ff[idx_ff];
   assign cur_pong    = pong_ff[idx_ff];
   assign cur_allowed = allowed_ff[idx_ff];
   assign missed      = $signed({1'b0, cur_span}) - $signed({1'b0, cur_pong});
   assign loss_lhs    = PROD_W'(missed) * $signed(PROD_W'(hblt_pkg::LOSS_SCALE));
   assign loss_rhs    = $signed(PROD_W'(cur_allowed) * PROD_W'(cur_span));
   assign lost        = loss_lhs > loss_rhs;
   assign walk_last   = (CNT_W'(idx_ff) + CNT_W'(1)) == total_ff;

   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      addr_in      = addr_ff;
      span_in      = span_ff;
      allowed_in   = allowed_ff;
      ping_in      = ping_ff;
      pong_in      = pong_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      cmd_take     = 1'b0;
      drop_en      = 1'b0;
      drop_idx     = hit_idx;

      unique case (state_ff)
         hblt_pkg::ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_take = 1'b1;
               if (cmd_word.mode == hblt_pkg::MODE_TICK) begin
                  if (total_ff != '0) begin
                     state_in = hblt_pkg::ST_WALK;
                     idx_in   = '0;
                  end
               end else begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.kind       = hblt_pkg::KIND_STATUS;
                  rsp_in.out_addr   = cmd_word.client_addr;
                  rsp_in.ping_value = '0;
                  rsp_in.status     = hblt_pkg::STATUS_OK;
                  rsp_in.last       = 1'b1;
                  unique case (cmd_word.mode)
                     hblt_pkg::MODE_ADD: begin
                        if (found) begin
                           rsp_in.status = hblt_pkg::STATUS_MISS;
                        end else if (total_ff == CNT_W'(MAX_PEERS)) begin
                           rsp_in.status = hblt_pkg::STATUS_FULL;
                        end else begin
                           addr_in[IDX_W'(total_ff)]    = cmd_word.client_addr;
                           span_in[IDX_W'(total_ff)]    = SPAN_BITS'(cmd_word.ping_span);
                           allowed_in[IDX_W'(total_ff)] = cmd_word.allowed_loss;
                           ping_in[IDX_W'(total_ff)]    = SPAN_BITS'(cmd_word.ping_span);
                           pong_in[IDX_W'(total_ff)]    = '0;
                           total_in = total_ff + CNT_W'(1);
                        end
                     end
                     hblt_pkg::MODE_REMOVE: begin
                        if (found) begin
                           drop_en = 1'b1;
                        end else begin
                           rsp_in.status = hblt_pkg::STATUS_MISS;
                        end
                     end
                     default: begin
                        if (!found) begin
                           rsp_in.status = hblt_pkg::STATUS_MISS;
                        end else if (pong_ff[hit_idx] != SPAN_MAX) begin
                           pong_in[hit_idx] = pong_ff[hit_idx] + SPAN_BITS'(1);
                        end
                     end
                  endcase
               end
            end
         end
         hblt_pkg::ST_WALK: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.out_addr = addr_ff[idx_ff];
               rsp_in.status   = hblt_pkg::STATUS_OK;
               rsp_in.last     = walk_last;
               if (cur_ping == '0 && lost) begin
                  rsp_in.kind       = hblt_pkg::KIND_DEAD;
                  rsp_in.ping_value = '0;
                  drop_en           = 1'b1;
                  drop_idx          = idx_ff;
               end else begin
                  rsp_in.kind       = hblt_pkg::KIND_PING;
                  rsp_in.ping_value = 10'(cur_ping);
                  if (cur_ping == '0) begin
                     pong_in[idx_ff] = '0;
                     ping_in[idx_ff] = cur_span;
                  end else begin
                     ping_in[idx_ff] = cur_ping - SPAN_BITS'(1);
                  end
                  idx_in = idx_ff + IDX_W'(1);
               end
               if (walk_last) begin
                  state_in = hblt_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = hblt_pkg::ST_IDLE;
      endcase

      // removal closes the gap so order is kept
      if (drop_en) begin
         for (int j = 0; j < MAX_PEERS - 1; j++) begin
            if (j >= int'(drop_idx)) begin
               addr_in[j]    = addr_ff[j+1];
               span_in[j]    = span_ff[j+1];
               allowed_in[j] = allowed_ff[j+1];
               ping_in[j]    = ping_ff[j+1];
               pong_in[j]    = pong_ff[j+1];
            end
         end
         total_in = total_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         idx_ff       <= '0;
         state_ff     <= hblt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         idx_ff       <= idx_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      span_ff    <= span_in;
      allowed_ff <= allowed_in;
      ping_ff    <= ping_in;
      pong_ff    <= pong_in;
      rsp_ff     <= rsp_in;
   end

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(MAX_PEERS))
      else $error("peer count above table size");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == hblt_pkg::ST_WALK |-> CNT_W'(idx_ff) < total_ff)
      else $error("walk index past last peer");

   a_walk_ends_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hblt_pkg::ST_WALK && state_in == hblt_pkg::ST_IDLE)
      |=> (rsp_valid_ff && rsp_ff.last))
      else $error("walk ended without a final word");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == hblt_pkg::ST_WALK |-> !cmd_take)
      else $error("request taken during walk");

endmodule

// ===== verif/tb_heartbeat_liveness_table.sv =====
// Testbench for the heartbeat liveness table: directed table, a receiver stall, then random traffic.
`timescale 1ns / 1ps
module tb_heartbeat_liveness_table;

   localparam int PEERS = 16;
   localparam logic [9:0] PONG_MAX = 10'h3FF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   hblt_pkg::req_type req_word = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   hblt_pkg::rsp_type rsp_word;

   always #4 clock = ~clock;

   heartbeat_liveness_table i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_word(req_word),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_word(rsp_word)
   );

   // peer table mirror, slots kept in insertion order
   logic [47:0] peer_addr[PEERS];
   logic [9:0] peer_span[PEERS];
   logic [6:0] peer_loss[PEERS];
   logic [9:0] peer_ping[PEERS];
   logic [9:0] peer_pongs[PEERS];
   int peer_total;

   hblt_pkg::rsp_type words_due[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit recv_hold = 1'b0;

   typedef struct {
      hblt_pkg::req_type word;
      bit has_fixed;
      hblt_pkg::rsp_type fixed;
   } stim_row_type;
   stim_row_type stim_rows[$];

   function automatic int find_peer(logic [47:0] addr);
      for (int i = 0; i < peer_total; i++)
         if (peer_addr[i] == addr) return i;
      return -1;
   endfunction

   function automatic void drop_peer(int s);
      for (int i = s; i + 1 < peer_total; i++) begin
         peer_addr[i] = peer_addr[i+1];
         peer_span[i] = peer_span[i+1];
         peer_loss[i] = peer_loss[i+1];
         peer_ping[i] = peer_ping[i+1];
         peer_pongs[i] = peer_pongs[i+1];
      end
      peer_total--;
   endfunction

   function automatic hblt_pkg::rsp_type mk_word(hblt_pkg::kind_type k, logic [47:0] a,
                                                 logic [9:0] pv, logic [1:0] st);
      hblt_pkg::rsp_type r;
      r.kind = k;
      r.out_addr = a;
      r.ping_value = pv;
      r.status = st;
      r.last = 1'b0;
      return r;
   endfunction

   // advance the mirror by one request and queue the words it causes
   function automatic void predict_liveness(hblt_pkg::req_type q);
      hblt_pkg::rsp_type outw[$];
      int s;
      int i;
      logic [1:0] st;
      longint missed;
      st = hblt_pkg::STATUS_OK;
      if (q.mode == hblt_pkg::MODE_TICK) begin
         i = 0;
         while (i < peer_total) begin
            if (peer_ping[i] == 0) begin
               missed = longint'(peer_span[i]) - longint'(peer_pongs[i]);
               if (100 * missed > longint'(peer_loss[i]) * longint'(peer_span[i])) begin
                  outw = {outw, mk_word(hblt_pkg::KIND_DEAD, peer_addr[i], '0,
                                        hblt_pkg::STATUS_OK)};
                  drop_peer(i);
                  continue;
               end
               peer_pongs[i] = '0;
            end
            outw = {outw, mk_word(hblt_pkg::KIND_PING, peer_addr[i], peer_ping[i],
                                  hblt_pkg::STATUS_OK)};
            if (peer_ping[i] > 0) peer_ping[i] = peer_ping[i] - 10'd1;
            else peer_ping[i] = peer_span[i];
            i++;
         end
      end else begin
         s = find_peer(q.client_addr);
         if (q.mode == hblt_pkg::MODE_ADD) begin
            if (s >= 0) st = hblt_pkg::STATUS_MISS;
            else if (peer_total >= PEERS) st = hblt_pkg::STATUS_FULL;
            else begin
               peer_addr[peer_total] = q.client_addr;
               peer_span[peer_total] = q.ping_span;
               peer_loss[peer_total] = q.allowed_loss;
               peer_ping[peer_total] = q.ping_span;
               peer_pongs[peer_total] = '0;
               peer_total++;
            end
         end else if (q.mode == hblt_pkg::MODE_REMOVE) begin
            if (s < 0) st = hblt_pkg::STATUS_MISS;
            else drop_peer(s);
         end else begin
            if (s < 0) st = hblt_pkg::STATUS_MISS;
            else if (peer_pongs[s] < PONG_MAX) peer_pongs[s] = peer_pongs[s] + 10'd1;
         end
         outw = {outw, mk_word(hblt_pkg::KIND_STATUS, q.client_addr, '0, st)};
      end
      if (outw.size() > 0) outw[outw.size()-1].last = 1'b1;
      foreach (outw[k]) words_due = {words_due, outw[k]};
   endfunction

   function automatic hblt_pkg::req_type mk_req(hblt_pkg::mode_type m, logic [47:0] a,
                                                logic [9:0] sp, logic [6:0] al);
      hblt_pkg::req_type q;
      q.mode = m;
      q.client_addr = a;
      q.ping_span = sp;
      q.allowed_loss = al;
      return q;
   endfunction

   task automatic add_row(hblt_pkg::req_type q, bit fixed_ok, hblt_pkg::rsp_type f);
      stim_row_type r;
      r.word = q;
      r.has_fixed = fixed_ok;
      r.fixed = f;
      stim_rows = {stim_rows, r};
   endtask

   // hand one word to the block; predictor runs at acceptance
   // push stays high after acceptance until the next call or drain_wait
   task automatic send_word(hblt_pkg::req_type q, bit has_fixed, hblt_pkg::rsp_type fixed);
      hblt_pkg::rsp_type due;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_word <= q;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_liveness(q);
      if (has_fixed && words_due.size() > 0) begin
         due = words_due[words_due.size()-1];
         if (due !== fixed) begin
            $display("%t table row disagrees: expected %h got %h", $time, fixed, due);
            errors++;
         end
      end
   endtask

   task automatic drain_wait();
      req_push <= 1'b0;
      while (words_due.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // result side: check each popped word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (words_due.size() == 0) begin
            $display("%t unexpected word: expected none got %h", $time, rsp_word);
            errors++;
         end else begin
            hblt_pkg::rsp_type e;
            e = words_due.pop_front();
            if (rsp_word.kind !== e.kind || rsp_word.out_addr !== e.out_addr ||
                rsp_word.ping_value !== e.ping_value || rsp_word.status !== e.status ||
                rsp_word.last !== e.last) begin
               $display("%t word mismatch: expected %h got %h", $time, e, rsp_word);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || recv_hold) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [47:0] rand_addr();
      return 48'({$urandom(), $urandom()});
   endfunction

   initial begin
      logic [47:0] pool[8];
      hblt_pkg::rsp_type nofix;
      hblt_pkg::rsp_type full_word;
      hblt_pkg::req_type q;
      int r;
      nofix = '0;
      peer_total = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table
      add_row(mk_req(hblt_pkg::MODE_TICK, '0, '0, '0), 0, nofix);  // empty table tick
      add_row(mk_req(hblt_pkg::MODE_REMOVE, 48'h1, '0, '0), 1,
              mk_word(hblt_pkg::KIND_STATUS, 48'h1, '0, hblt_pkg::STATUS_MISS) |
              hblt_pkg::rsp_type'(1));
      add_row(mk_req(hblt_pkg::MODE_PONG, 48'hFFFF_FFFF_FFFF, '0, '0), 1,
              mk_word(hblt_pkg::KIND_STATUS, 48'hFFFF_FFFF_FFFF, '0, hblt_pkg::STATUS_MISS) |
              hblt_pkg::rsp_type'(1));
      add_row(mk_req(hblt_pkg::MODE_ADD, 48'h0, 10'd0, 7'd0), 1,
              mk_word(hblt_pkg::KIND_STATUS, 48'h0, '0, hblt_pkg::STATUS_OK) |
              hblt_pkg::rsp_type'(1));
      add_row(mk_req(hblt_pkg::MODE_ADD, 48'h0, 10'd5, 7'd5), 1,
              mk_word(hblt_pkg::KIND_STATUS, 48'h0, '0, hblt_pkg::STATUS_MISS) |
              hblt_pkg::rsp_type'(1));
      add_row(mk_req(hblt_pkg::MODE_ADD, 48'hFFFF_FFFF_FFFF, 10'h3FF, 7'h7F), 0, nofix);
      add_row(mk_req(hblt_pkg::MODE_ADD, 48'hA5A5_5A5A_0001, 10'd1, 7'd100), 0, nofix);
      add_row(mk_req(hblt_pkg::MODE_ADD, 48'h5A5A_A5A5_0002, 10'd2, 7'd0), 0, nofix);
      add_row(mk_req(hblt_pkg::MODE_ADD, 48'h0000_0000_0003, 10'd1, 7'd0), 0, nofix);
      add_row(mk_req(hblt_pkg::MODE_PONG, 48'h0000_0000_0003, '0, '0), 0, nofix);
      add_row(mk_req(hblt_pkg::MODE_PONG, 48'h0000_0000_0003, '0, '0), 0, nofix);
      for (int k = 0; k < 4; k++)
         add_row(mk_req(hblt_pkg::MODE_TICK, '0, '0, '0), 0, nofix);
      add_row(mk_req(hblt_pkg::MODE_REMOVE, 48'h0, '0, '0), 0, nofix);
      for (int k = 0; k < 17; k++)
         add_row(mk_req(hblt_pkg::MODE_ADD, 48'h1000 + k, 10'd3, 7'd50), 0, nofix);
      full_word = mk_word(hblt_pkg::KIND_STATUS, 48'h2000, '0, hblt_pkg::STATUS_FULL);
      full_word.last = 1'b1;
      add_row(mk_req(hblt_pkg::MODE_ADD, 48'h2000, 10'd3, 7'd50), 1, full_word);
      add_row(mk_req(hblt_pkg::MODE_TICK, '0, '0, '0), 0, nofix);

      foreach (stim_rows[k]) send_word(stim_rows[k].word, stim_rows[k].has_fixed,
                                       stim_rows[k].fixed);
      drain_wait();
      // empty the table again
      for (int k = 0; k < 24; k++) begin
         if (peer_total == 0) break;
         send_word(mk_req(hblt_pkg::MODE_REMOVE, peer_addr[0], '0, '0), 0, nofix);
      end

      // receiver stalls long while sender keeps pushing
      fork
         begin
            recv_hold = 1'b1;
            for (int c = 0; c < 300; c++) @(posedge clock);
            recv_hold = 1'b0;
         end
         for (int k = 0; k < 10; k++)
            send_word(mk_req(hblt_pkg::MODE_PONG, rand_addr(), '0, '0), 0, nofix);
      join
      drain_wait();

      foreach (pool[k]) pool[k] = rand_addr();
      pool[0] = 48'h0;
      pool[1] = 48'hFFFF_FFFF_FFFF;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 77 : 0;
         recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 26 : 0;
         for (int k = 0; k < 20; k++) begin
            r = $urandom_range(99);
            q = mk_req(hblt_pkg::MODE_TICK, rand_addr(), 10'($urandom()), 7'($urandom()));
            if (r < 25) begin
               q.mode = hblt_pkg::MODE_ADD;
               q.client_addr = pool[$urandom_range(7)];
               q.ping_span = ($urandom_range(9) == 0) ? 10'($urandom()) :
                             10'($urandom_range(4));
               q.allowed_loss = ($urandom_range(4) == 0) ? 7'($urandom()) :
                                7'($urandom_range(100));
            end else if (r < 35) begin
               q.mode = hblt_pkg::MODE_REMOVE;
               if (r < 33) q.client_addr = pool[$urandom_range(7)];
            end else if (r < 65) begin
               q.mode = hblt_pkg::MODE_PONG;
               if (r < 62) q.client_addr = pool[$urandom_range(7)];
            end
            send_word(q, 0, nofix);
         end
         drain_wait();
      end
      recv_idle_pct = 0;
      drain_wait();
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #3000000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
